[src/gww_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gww_pkg: shared types and constants for the greedy word wrap block
// Result item layout, result bundle and character/register codes.
// ----------------------------------------------------------------------------
package gww_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  // Configuration register indexes
  localparam logic REG_MAX_LINE_WIDTH = 1'b0;
  localparam logic REG_SPACE_WIDTH    = 1'b1;

  // Result kinds
  localparam logic KIND_BREAK = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Results one character can cause, and the count width
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = 3;

  // Reset values of the configuration registers
  localparam logic [15:0] MAX_LINE_WIDTH_RST = 16'd640;
  localparam logic [7:0]  SPACE_WIDTH_RST    = 8'd4;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] break_position;
    logic        fits_ok;
    logic        last_result;
  } gww_result_t;

  typedef struct packed {
    gww_result_t [MAX_RESULTS-1:0] items;
    logic [CNT_W-1:0]              count;
  } gww_bundle_t;

endpackage

[src/gww_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gww_step: wrap decision for one character
// Next line state and the bundle of results the character causes.
// ----------------------------------------------------------------------------
module gww_step #(
  parameter int WIDTH_BITS   = 24,
  parameter int MAX_TEXT_LEN = 65536
) (
  input  logic [7:0]                        char_code,
  input  logic [7:0]                        glyph_width,
  input  logic                              last_char,
  input  logic [15:0]                       max_line_width,
  input  logic [7:0]                        space_width,
  input  logic [WIDTH_BITS-1:0]             line_width,
  input  logic [WIDTH_BITS-1:0]             word_width,
  input  logic                              cand_valid,
  input  logic [$clog2(MAX_TEXT_LEN)-1:0]   cand_pos,
  input  logic [$clog2(MAX_TEXT_LEN)-1:0]   char_index,
  input  logic                              all_fit,
  output logic [WIDTH_BITS-1:0]             line_width_next,
  output logic [WIDTH_BITS-1:0]             word_width_next,
  output logic                              cand_valid_next,
  output logic [$clog2(MAX_TEXT_LEN)-1:0]   cand_pos_next,
  output logic [$clog2(MAX_TEXT_LEN)-1:0]   char_index_next,
  output logic                              all_fit_next,
  output gww_pkg::gww_bundle_t              bundle
);
  import gww_pkg::*;

  localparam int W  = WIDTH_BITS;
  localparam int IW = $clog2(MAX_TEXT_LEN);
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_TEXT_LEN - 1);

  typedef struct packed {
    logic [W-1:0]                  lw;
    logic [W-1:0]                  ww;
    logic                          cv;
    logic [IW-1:0]                 cp;
    logic                          af;
    logic [CNT_W-1:0]              n;
    gww_result_t [MAX_RESULTS-1:0] res;
  } wk_t;

  function automatic logic [W-1:0] sat_add(logic [W-1:0] a, logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W] ? {W{1'b1}} : s[W-1:0];
  endfunction

  function automatic wk_t emit(wk_t w, logic kind, logic [IW-1:0] p, logic fits);
    wk_t r;
    r = w;
    r.res[w.n[1:0]].result_kind    = kind;
    r.res[w.n[1:0]].break_position = 16'(p);
    r.res[w.n[1:0]].fits_ok        = fits;
    r.res[w.n[1:0]].last_result    = 1'b0;
    r.n = w.n + 1'b1;
    return r;
  endfunction

  function automatic wk_t clear_line(wk_t w);
    wk_t r;
    r = w;
    r.lw = '0;
    r.ww = '0;
    r.cv = 1'b0;
    r.cp = '0;
    return r;
  endfunction

  // A space: at most two passes, the second after breaking at the candidate
  function automatic wk_t do_space(wk_t w, logic [IW-1:0] p, logic in_text,
                                   logic [15:0] maxw, logic [7:0] sw);
    wk_t  r;
    logic done;
    r    = w;
    done = 1'b0;
    for (int k = 0; k < 2; k++) begin
      if (!done) begin
        r.lw = sat_add(r.lw, W'(sw));
        if (r.lw < W'(maxw)) begin
          r.cv = 1'b1;
          r.cp = p;
          r.ww = '0;
          done = 1'b1;
        end else if (r.cv) begin
          r    = emit(r, KIND_BREAK, r.cp, 1'b0);
          r.lw = r.ww;
          r.cv = 1'b0;
        end else begin
          if (in_text) r = emit(r, KIND_BREAK, p, 1'b0);
          r.af = 1'b0;
          r    = clear_line(r);
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  wk_t           w;
  logic [IW-1:0] idx_inc;

  assign idx_inc = (char_index == IDX_LAST) ? '0 : char_index + 1'b1;

  always_comb begin
    w.lw  = line_width;
    w.ww  = word_width;
    w.cv  = cand_valid;
    w.cp  = cand_pos;
    w.af  = all_fit;
    w.n   = '0;
    w.res = '0;

    if (char_code == CH_NEWLINE) begin
      // newline is already a break: no edit for the forced case
      if (w.lw > W'(max_line_width)) begin
        if (w.cv) begin
          w    = emit(w, KIND_BREAK, w.cp, 1'b0);
          w.lw = w.ww;
          w.cv = 1'b0;
          if (w.lw > W'(max_line_width)) w.af = 1'b0;
        end else begin
          w.af = 1'b0;
        end
      end
      w = clear_line(w);
    end else if (char_code == CH_SPACE) begin
      w = do_space(w, char_index, 1'b1, max_line_width, space_width);
    end else begin
      w.lw = sat_add(w.lw, W'(glyph_width));
      w.ww = sat_add(w.ww, W'(glyph_width));
    end

    if (last_char) begin
      // implicit trailing space, then the end report
      w = do_space(w, idx_inc, 1'b0, max_line_width, space_width);
      w = emit(w, KIND_END, '0, w.af);
      w = clear_line(w);
      w.af = 1'b1;
      char_index_next = '0;
    end else begin
      char_index_next = idx_inc;
    end

    if (w.n != '0) w.res[2'(w.n - 1'b1)].last_result = 1'b1;
  end

  assign line_width_next = w.lw;
  assign word_width_next = w.ww;
  assign cand_valid_next = w.cv;
  assign cand_pos_next   = w.cp;
  assign all_fit_next    = w.af;
  assign bundle.items    = w.res;
  assign bundle.count    = w.n;

endmodule

[src/gww_serial.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gww_serial: result register and output serialiser
// Holds one bundle of results and hands them out one result per cycle while m_axis_tready is high.
// ----------------------------------------------------------------------------
module gww_serial (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  gww_pkg::gww_bundle_t bundle,
  output logic                 can_load,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // break_position, fits_ok, zero pad
  output logic                 m_axis_tuser,   // result_kind
  output logic                 m_axis_tlast    // last_result
);
  import gww_pkg::*;

  gww_result_t [MAX_RESULTS-1:0] items;
  logic [CNT_W-1:0]              count;
  logic [1:0]                    rd;
  logic                          busy;
  logic                          take;
  logic                          last_take;
  gww_result_t                   cur;

  assign cur       = items[rd];
  assign take      = busy && m_axis_tready;
  assign last_take = take && ({1'b0, rd} == count - 1'b1);
  assign can_load  = !busy || last_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd   <= '0;
    end else if (load) begin
      busy <= 1'b1;
      rd   <= '0;
    end else if (last_take) begin
      busy <= 1'b0;
    end else if (take) begin
      rd <= rd + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= bundle.items;
      count <= bundle.count;
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = {7'd0, cur.fits_ok, cur.break_position};
  assign m_axis_tuser  = cur.result_kind;
  assign m_axis_tlast  = cur.last_result;

endmodule

[src/greedy_word_wrap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap: greedy line breaking over a character stream
// Emits break edits and an end-of-text report with the fits flag.
// ----------------------------------------------------------------------------
// Characters enter through an input register; the wrap decision for the
// registered character is combinational, and its results (up to four) go
// into the result register, from which the output takes one per cycle
// while the receiver is ready. A character with no result (an ordinary
// glyph or a fitting space) never waits, so text streams at one character
// per cycle; one with results waits in the input register until the
// result register can take them. No clearing pass after reset. The user
// must write configuration only while the block is idle; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module greedy_word_wrap #(
  parameter int MAX_TEXT_LEN = 65536,
  parameter int WIDTH_BITS   = 24
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // character stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // char_code, glyph_width
  input  logic        s_axis_tlast,    // last_char
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // break_position, fits_ok, zero pad
  output logic        m_axis_tuser,    // result_kind
  output logic        m_axis_tlast     // last_result
);
  import gww_pkg::*;

  localparam int IW = $clog2(MAX_TEXT_LEN);

  // Configuration registers
  logic [15:0] max_line_width;
  logic [7:0]  space_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_width <= MAX_LINE_WIDTH_RST;
      space_width    <= SPACE_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_LINE_WIDTH: max_line_width <= cfg_data;
        REG_SPACE_WIDTH:    space_width    <= cfg_data[7:0];
        default:            ;
      endcase
    end
  end

  // Input register
  logic       in_v;
  logic [7:0] in_code;
  logic [7:0] in_glyph;
  logic       in_last;

  // Line state
  logic [WIDTH_BITS-1:0] line_width, line_width_next;
  logic [WIDTH_BITS-1:0] word_width, word_width_next;
  logic                  cand_valid, cand_valid_next;
  logic [IW-1:0]         cand_pos, cand_pos_next;
  logic [IW-1:0]         char_index, char_index_next;
  logic                  all_fit, all_fit_next;

  gww_bundle_t bundle;
  logic        can_load;
  logic        fire;
  logic        load;

  // The registered character retires when its results (if any) can go
  // into the result register; a character with none never waits.
  assign fire          = in_v && ((bundle.count == '0) || can_load);
  assign load          = fire && (bundle.count != '0);
  assign s_axis_tready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_code  <= s_axis_tdata[7:0];
      in_glyph <= s_axis_tdata[15:8];
      in_last  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= '0;
      word_width <= '0;
      cand_valid <= 1'b0;
      cand_pos   <= '0;
      char_index <= '0;
      all_fit    <= 1'b1;
    end else if (fire) begin
      line_width <= line_width_next;
      word_width <= word_width_next;
      cand_valid <= cand_valid_next;
      cand_pos   <= cand_pos_next;
      char_index <= char_index_next;
      all_fit    <= all_fit_next;
    end
  end

  gww_step #(
    .WIDTH_BITS  (WIDTH_BITS),
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_step (
    .char_code      (in_code),
    .glyph_width    (in_glyph),
    .last_char      (in_last),
    .max_line_width (max_line_width),
    .space_width    (space_width),
    .line_width     (line_width),
    .word_width     (word_width),
    .cand_valid     (cand_valid),
    .cand_pos       (cand_pos),
    .char_index     (char_index),
    .all_fit        (all_fit),
    .line_width_next(line_width_next),
    .word_width_next(word_width_next),
    .cand_valid_next(cand_valid_next),
    .cand_pos_next  (cand_pos_next),
    .char_index_next(char_index_next),
    .all_fit_next   (all_fit_next),
    .bundle         (bundle)
  );

  gww_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .bundle       (bundle),
    .can_load     (can_load),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // End of text resets the position counter
  a_eot_index: assert property (@(posedge clk) disable iff (rst)
    fire && in_last |=> char_index == '0)
    else $error("char index not cleared after end of text");

  // The end report is always the final result of its character
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_END) |-> m_axis_tlast)
    else $error("end report not marked last");

  // A stalled character stays in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_v && !fire |=> in_v && $stable(in_code) && $stable(in_last))
    else $error("input register lost a stalled character");

  // Only an end-of-text character sets all_fit again once a forced break cleared it
  a_fit_clear: assert property (@(posedge clk) disable iff (rst)
    fire && !in_last && !all_fit |=> !all_fit)
    else $error("fits flag set again before end of text");

endmodule

[test/wrap_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrap_checker: result predictor and scoreboard for greedy_word_wrap
// Snoops config writes and both stream channels, predicts the break edits
// and end-of-text reports and compares them in order with the block output.
// ----------------------------------------------------------------------------
module wrap_checker
  import gww_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // char_code, glyph_width
  input  logic        s_axis_tlast,    // last_char
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,    // break_position, fits_ok, zero pad
  input  logic        m_axis_tuser,    // result_kind
  input  logic        m_axis_tlast,    // last_result
  output int          mismatches,
  output int          pending
);

  // mirrored registers and wrap state
  logic [15:0] max_w;
  logic [7:0]  space_w;
  logic [23:0] line_w;
  logic [23:0] word_w;
  logic        cand_ok;
  logic [15:0] cand_pos;
  logic [15:0] char_idx;
  logic        all_fit;

  gww_result_t step_events[$];
  gww_result_t wrap_events_due[$];

  function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? 24'hFF_FFFF : s[23:0];
  endfunction

  task automatic clear_line();
    line_w   = '0;
    word_w   = '0;
    cand_ok  = 1'b0;
    cand_pos = '0;
  endtask

  task automatic note_break(input logic [15:0] pos);
    gww_result_t r;
    r = '0;
    r.result_kind    = KIND_BREAK;
    r.break_position = pos;
    step_events.push_back(r);
  endtask

  // a space that does not fit breaks at the candidate and is tried again
  task automatic wrap_space(input logic [15:0] pos, input logic in_text);
    bit done;
    done = 1'b0;
    while (!done) begin
      line_w = sat_add(line_w, {16'd0, space_w});
      if (line_w < {8'd0, max_w}) begin
        cand_ok  = 1'b1;
        cand_pos = pos;
        word_w   = '0;
        done     = 1'b1;
      end else if (cand_ok) begin
        note_break(cand_pos);
        line_w  = word_w;
        cand_ok = 1'b0;
      end else begin
        if (in_text) note_break(pos);
        all_fit = 1'b0;
        clear_line();
        done = 1'b1;
      end
    end
  endtask

  task automatic wrap_newline();
    while (line_w > {8'd0, max_w} && cand_ok) begin
      note_break(cand_pos);
      line_w  = word_w;
      cand_ok = 1'b0;
    end
    if (line_w > {8'd0, max_w}) all_fit = 1'b0;
    clear_line();
  endtask

  task automatic wrap_char(input logic [7:0] code, input logic [7:0] glyph,
                           input logic last);
    logic [15:0] pos;
    logic [15:0] nxt;
    gww_result_t r;
    pos = char_idx;
    nxt = char_idx + 16'd1;
    step_events.delete();
    if (code == CH_NEWLINE) begin
      wrap_newline();
    end else if (code == CH_SPACE) begin
      wrap_space(pos, 1'b1);
    end else begin
      line_w = sat_add(line_w, {16'd0, glyph});
      word_w = sat_add(word_w, {16'd0, glyph});
    end
    if (last) begin
      // implicit trailing space, then the report
      wrap_space(nxt, 1'b0);
      r = '0;
      r.result_kind = KIND_END;
      r.fits_ok     = all_fit;
      step_events.push_back(r);
      clear_line();
      char_idx = '0;
      all_fit  = 1'b1;
    end else begin
      char_idx = nxt;
    end
    if (step_events.size() > 0) begin
      r = step_events.pop_back();
      r.last_result = 1'b1;
      step_events.push_back(r);
    end
    foreach (step_events[i]) wrap_events_due.push_back(step_events[i]);
  endtask

  always @(posedge clk) begin
    gww_result_t seen;
    gww_result_t want;
    if (rst) begin
      max_w    = MAX_LINE_WIDTH_RST;
      space_w  = SPACE_WIDTH_RST;
      char_idx = '0;
      all_fit  = 1'b1;
      clear_line();
      wrap_events_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_LINE_WIDTH) max_w = cfg_data;
        else space_w = cfg_data[7:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        wrap_char(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        seen = '0;
        seen.result_kind    = m_axis_tuser;
        seen.break_position = m_axis_tdata[15:0];
        seen.fits_ok        = m_axis_tdata[16];
        seen.last_result    = m_axis_tlast;
        if (wrap_events_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result kind %0b pos %0d fits %0b last %0b",
                     $time, seen.result_kind, seen.break_position, seen.fits_ok,
                     seen.last_result);
          mismatches++;
        end else begin
          want = wrap_events_due.pop_front();
          if (seen !== want) begin
            if (mismatches < 10)
              $display("%0t: result differs: kind %0b/%0b pos %0d/%0d fits %0b/%0b last %0b/%0b (exp/got)",
                       $time, want.result_kind, seen.result_kind,
                       want.break_position, seen.break_position,
                       want.fits_ok, seen.fits_ok, want.last_result, seen.last_result);
            mismatches++;
          end
        end
      end
    end
    pending = wrap_events_due.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for greedy_word_wrap
// Drives directed and random texts through several register settings, with
// random gaps on both channels; wrap_checker does all the prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import gww_pkg::*;

  localparam logic [7:0] LETTER_A     = 8'h61;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         HOLD_CYCLES  = 300; // long receiver back-off

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;     // char_code, glyph_width
  logic        s_axis_tlast;     // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;     // break_position, fits_ok, zero pad
  logic        m_axis_tuser;     // result_kind
  logic        m_axis_tlast;     // last_result

  int mismatches;
  int pending;

  // idle modes per phase; hold_req asks the receiver for one long back-off
  bit tx_idle;
  bit rx_idle;
  bit hold_req = 1'b0;
  int chars_sent;

  always #5 clk = ~clk;

  greedy_word_wrap dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  wrap_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // --------------------------------------------------------------------------
  // Sender side. Called at a falling edge, returns at the falling edge after
  // the request is taken. tvalid stays high between back-to-back requests.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] code, input logic [7:0] glyph,
                           input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {glyph, code};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    chars_sent++;
  endtask

  // Sender pauses until every predicted result is out, then lets the
  // block settle (a glyph or fitting space gives no result to wait on).
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Both registers, written back to back; only called when idle.
  // Upper byte of the space write is junk the block must ignore.
  task automatic set_config(input logic [15:0] maxw, input logic [7:0] spw);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_LINE_WIDTH;
    cfg_data  <= maxw;
    @(negedge clk);
    cfg_index <= REG_SPACE_WIDTH;
    cfg_data  <= {8'($urandom), spw};
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One text, ending on a last_char request. Mostly words of letters with
  // spaces and the odd newline; one in five is raw noise over every code.
  task automatic send_text(input int gmax);
    int n_words;
    int n_letters;
    logic [7:0] glyph;
    if ($urandom_range(0, 4) == 0) begin
      n_words = $urandom_range(1, 12);
      for (int i = 0; i < n_words; i++)
        send_char(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  (i == n_words - 1) || ($urandom_range(0, 15) == 0));
    end else begin
      n_words = $urandom_range(1, 8);
      for (int w = 0; w < n_words; w++) begin
        n_letters = $urandom_range(1, 8);
        for (int c = 0; c < n_letters; c++) begin
          glyph = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(1, gmax));
          send_char(LETTER_A + 8'($urandom_range(0, 25)), glyph,
                    (w == n_words - 1) && (c == n_letters - 1) &&
                    ($urandom_range(0, 3) != 0));
        end
        if (w == n_words - 1) begin
          // text ended on a letter unless the draw above left it open
          if (s_axis_tlast !== 1'b1)
            send_char(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_NEWLINE,
                      8'($urandom_range(0, 255)), 1'b1);
        end else if ($urandom_range(0, 7) == 0) begin
          send_char(CH_NEWLINE, 8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_char(CH_SPACE, 8'($urandom_range(0, 255)), 1'b0);
          if ($urandom_range(0, 9) == 0)
            send_char(CH_SPACE, 8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
  endtask

  // One register setting: drain, write, then texts until the quota is met.
  // Glyphs are scaled to the line limit so breaks actually happen.
  task automatic run_phase(input logic [15:0] maxw, input logic [7:0] spw,
                           input int n_chars, input bit pause_mid);
    int gmax;
    int start;
    bit paused;
    drain_results();
    set_config(maxw, spw);
    gmax   = int'(maxw) / 6;
    gmax   = (gmax < 4) ? 4 : (gmax > 255) ? 255 : gmax;
    start  = chars_sent;
    paused = 1'b0;
    while (chars_sent - start < n_chars) begin
      send_text(gmax);
      if (pause_mid && !paused && (chars_sent - start >= n_chars / 2)) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: a random back-off before each result, or the one long
  // back-off when asked, counted here in its own loop.
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = rx_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Main stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_MAX_LINE_WIDTH;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    chars_sent    = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: narrow 40 px line, 4 px space
    set_config(16'd40, 8'd4);
    send_char(LETTER_A, 8'd0, 1'b0);           // zero-width glyph
    send_char(8'hFF, 8'd255, 1'b0);            // top code, widest glyph
    send_char(CH_SPACE, 8'd255, 1'b0);         // no candidate: break at the space
    send_char(LETTER_A, 8'd10, 1'b0);
    send_char(LETTER_A, 8'd10, 1'b0);
    send_char(CH_SPACE, 8'd0, 1'b0);           // fits, becomes candidate
    send_char(LETTER_A, 8'd10, 1'b0);
    send_char(LETTER_A, 8'd10, 1'b0);
    send_char(CH_SPACE, 8'd9, 1'b0);           // break at candidate, space refits
    send_char(LETTER_A, 8'd10, 1'b0);
    send_char(LETTER_A, 8'd10, 1'b0);
    send_char(CH_NEWLINE, 8'd7, 1'b0);         // overflowing line with candidate
    send_char(LETTER_A, 8'd50, 1'b0);
    send_char(CH_NEWLINE, 8'd0, 1'b0);         // overflow, no candidate: no edit
    send_char(LETTER_A, 8'd40, 1'b0);
    send_char(CH_NEWLINE, 8'd255, 1'b0);       // exactly at the limit is fine
    send_char(LETTER_A, 8'd36, 1'b0);
    send_char(CH_SPACE, 8'd0, 1'b0);           // lands on the limit: not a fit
    send_char(8'h00, 8'd20, 1'b0);
    send_char(CH_SPACE, 8'd0, 1'b0);
    send_char(LETTER_A, 8'd30, 1'b1);          // trailing space breaks at candidate
    send_char(LETTER_A, 8'd10, 1'b1);          // short text that fits
    send_char(LETTER_A, 8'd2, 1'b0);
    send_char(CH_SPACE, 8'd0, 1'b0);
    send_char(LETTER_A, 8'd33, 1'b0);
    send_char(CH_SPACE, 8'd0, 1'b1);           // three results from one request

    // Random phases; register extremes included
    run_phase(16'd640, 8'd4, 30, 1'b0);        // reset values
    tx_idle = 1'b0;
    run_phase(16'd0, 8'd0, 20, 1'b0);
    // long receiver back-off while the sender keeps pushing
    rx_idle  = 1'b0;
    hold_req = 1'b1;
    run_phase(16'd60, 8'd8, 30, 1'b0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_phase(16'd120, 8'd12, 30, 1'b1);       // sender pause mid-phase
    run_phase(16'hFFFF, 8'd255, 20, 1'b0);
    rx_idle = 1'b0;
    run_phase(16'd0, 8'd255, 20, 1'b0);
    rx_idle = 1'b1;
    tx_idle = 1'b0;
    run_phase(16'hFFFF, 8'd0, 20, 1'b0);
    tx_idle = 1'b1;
    run_phase(16'd25, 8'd5, 25, 1'b0);

    drain_results();
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
